[sv/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define MFM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define MFM_ASSERT_NEXT(lbl, clk, rst_n, cond, res, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`else

`define MFM_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFM_ASSERT_NEXT(lbl, clk, rst_n, cond, res, msg)

`endif

`endif

[sv/mfm_pkg.sv]
// types, constants and the crc step for the mfm track formatter
package mfm_pkg;

    // track layout segments
    typedef enum logic [3:0] {
        SEG_GAP1,
        SEG_GAP2A,
        SEG_GAP2B,
        SEG_IDAM,
        SEG_IDBODY,
        SEG_IDCRC,
        SEG_GAP3A,
        SEG_GAP3B1,
        SEG_GAP3B2,
        SEG_DAM,
        SEG_DATA,
        SEG_DATACRC,
        SEG_GAP4,
        SEG_GAP5
    } segment_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRACK   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS = 2'd2;
    localparam int unsigned CFG_DATA_W = 7;

    // fixed byte values
    localparam logic [7:0] GAP_BYTE  = 8'h4E;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE = 8'hA1;
    localparam logic [7:0] IDAM_BYTE = 8'hFE;
    localparam logic [7:0] DAM_BYTE  = 8'hFB;
    localparam logic [7:0] SIZE_CODE = 8'h02;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    localparam logic [9:0] SECTOR_BYTES = 10'd512;
    localparam logic [9:0] IDBODY_LEN   = 10'd4;
    localparam logic [9:0] CRC_LEN      = 10'd2;
    localparam logic [9:0] MARK_LEN     = 10'd1;

    // gap table column codes
    localparam logic [2:0] GAP_1     = 3'd0;
    localparam logic [2:0] GAP_2_00  = 3'd1;
    localparam logic [2:0] GAP_2_A1  = 3'd2;
    localparam logic [2:0] GAP_3_4E  = 3'd3;
    localparam logic [2:0] GAP_3_00  = 3'd4;
    localparam logic [2:0] GAP_3_A1  = 3'd5;
    localparam logic [2:0] GAP_4     = 3'd6;
    localparam logic [2:0] GAP_5     = 3'd7;

    typedef struct packed {
        logic [6:0] track_number;
        logic       side_select;
        logic [3:0] sector_total;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  track_byte;
        logic        data_taken;
        logic [12:0] track_position;
        logic        end_of_track;
    } beat_t;

    // gap lengths per layout row (9, 10, 11 sectors)
    function automatic logic [9:0] gap_len(input logic [1:0] row, input logic [2:0] col);
        logic [9:0] len;
        len = 10'd1;
        case (row)
            2'd0, 2'd1:
            begin
                case (col)
                    GAP_1:    len = 10'd60;
                    GAP_2_00: len = 10'd12;
                    GAP_2_A1: len = 10'd3;
                    GAP_3_4E: len = 10'd22;
                    GAP_3_00: len = 10'd12;
                    GAP_3_A1: len = 10'd3;
                    GAP_4:    len = 10'd40;
                    default:  len = (row == 2'd0) ? 10'd664 : 10'd50;
                endcase
            end
            default:
            begin
                case (col)
                    GAP_1:    len = 10'd10;
                    GAP_2_00: len = 10'd3;
                    GAP_2_A1: len = 10'd3;
                    GAP_3_4E: len = 10'd22;
                    GAP_3_00: len = 10'd12;
                    GAP_3_A1: len = 10'd3;
                    GAP_4:    len = 10'd1;
                    default:  len = 10'd14;
                endcase
            end
        endcase
        return len;
    endfunction

    // ccitt crc over one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[sv/mfm_if.sv]
// valid/ready channel interfaces for input data and track beats
interface mfm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mfm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  track_byte;
    logic        data_taken;
    logic [12:0] track_position;
    logic        end_of_track;

    modport source (output valid, output track_byte, output data_taken,
                    output track_position, output end_of_track, input ready);
    modport sink   (input valid, input track_byte, input data_taken,
                    input track_position, input end_of_track, output ready);
endinterface

[sv/mfm_seq.sv]
// track layout sequencer: segment counters, byte select and crc
`include "assert_macros.svh"

module mfm_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  mfm_pkg::cfg_t cfg,
    input  logic          advance,
    input  logic [7:0]    data_byte,
    output mfm_pkg::beat_t beat
);
    import mfm_pkg::*;

    segment_t    segment_reg, segment_next;
    logic [9:0]  count_reg, count_next;
    logic [3:0]  sector_index_reg, sector_index_next;
    logic [15:0] crc_reg, crc_next;
    logic [12:0] offset_reg, offset_next;

    logic [3:0]  row_diff;
    logic [1:0]  row;
    logic [3:0]  nsec;
    logic        last_sector;
    logic [7:0]  byte_val;
    logic [9:0]  len;
    segment_t    seg_after;
    logic        crc_en;
    logic        crc_seed;
    logic        taken;
    logic        seg_end;
    logic        eot;
    logic [15:0] crc_base;
    logic [4:0]  sector_plus;

    // layout row from sector count, clamped to the table
    assign row_diff    = cfg.sector_total - 4'd9;
    assign row         = (cfg.sector_total < 4'd9)  ? 2'd0 :
                         (cfg.sector_total > 4'd11) ? 2'd2 : row_diff[1:0];
    assign nsec        = 4'd9 + {2'b00, row};
    assign sector_plus = {1'b0, sector_index_reg} + 5'd1;
    assign last_sector = sector_plus >= {1'b0, nsec};

    // byte, segment length and successor for the current segment
    always_comb
    begin
        byte_val  = GAP_BYTE;
        len       = gap_len(row, GAP_5);
        seg_after = SEG_GAP1;
        crc_en    = 1'b0;
        crc_seed  = 1'b0;
        taken     = 1'b0;
        unique case (segment_reg)
            SEG_GAP1:
            begin
                len       = gap_len(row, GAP_1);
                seg_after = SEG_GAP2A;
            end
            SEG_GAP2A:
            begin
                byte_val  = ZERO_BYTE;
                len       = gap_len(row, GAP_2_00);
                seg_after = SEG_GAP2B;
            end
            SEG_GAP2B:
            begin
                byte_val  = SYNC_BYTE;
                crc_en    = 1'b1;
                crc_seed  = (count_reg == 10'd0);
                len       = gap_len(row, GAP_2_A1);
                seg_after = SEG_IDAM;
            end
            SEG_IDAM:
            begin
                byte_val  = IDAM_BYTE;
                crc_en    = 1'b1;
                len       = MARK_LEN;
                seg_after = SEG_IDBODY;
            end
            SEG_IDBODY:
            begin
                case (count_reg)
                    10'd0:   byte_val = {1'b0, cfg.track_number};
                    10'd1:   byte_val = {7'd0, cfg.side_select};
                    10'd2:   byte_val = {3'd0, sector_plus};
                    default: byte_val = SIZE_CODE;
                endcase
                crc_en    = 1'b1;
                len       = IDBODY_LEN;
                seg_after = SEG_IDCRC;
            end
            SEG_IDCRC:
            begin
                byte_val  = (count_reg == 10'd0) ? crc_reg[15:8] : crc_reg[7:0];
                len       = CRC_LEN;
                seg_after = SEG_GAP3A;
            end
            SEG_GAP3A:
            begin
                len       = gap_len(row, GAP_3_4E);
                seg_after = SEG_GAP3B1;
            end
            SEG_GAP3B1:
            begin
                byte_val  = ZERO_BYTE;
                len       = gap_len(row, GAP_3_00);
                seg_after = SEG_GAP3B2;
            end
            SEG_GAP3B2:
            begin
                byte_val  = SYNC_BYTE;
                crc_en    = 1'b1;
                crc_seed  = (count_reg == 10'd0);
                len       = gap_len(row, GAP_3_A1);
                seg_after = SEG_DAM;
            end
            SEG_DAM:
            begin
                byte_val  = DAM_BYTE;
                crc_en    = 1'b1;
                len       = MARK_LEN;
                seg_after = SEG_DATA;
            end
            SEG_DATA:
            begin
                byte_val  = data_byte;
                taken     = 1'b1;
                crc_en    = 1'b1;
                len       = SECTOR_BYTES;
                seg_after = SEG_DATACRC;
            end
            SEG_DATACRC:
            begin
                byte_val  = (count_reg == 10'd0) ? crc_reg[15:8] : crc_reg[7:0];
                len       = CRC_LEN;
                seg_after = SEG_GAP4;
            end
            SEG_GAP4:
            begin
                len       = gap_len(row, GAP_4);
                seg_after = last_sector ? SEG_GAP5 : SEG_GAP2A;
            end
            SEG_GAP5:
            begin
                seg_after = SEG_GAP1;
            end
            default:
            begin
                seg_after = SEG_GAP1;
            end
        endcase
    end

    // segment end, sector step and crc update
    assign seg_end  = ({1'b0, count_reg} + 11'd1) >= {1'b0, len};
    assign eot      = seg_end && (seg_after == SEG_GAP1);
    assign crc_base = crc_seed ? CRC_SEED : crc_reg;

    always_comb
    begin
        segment_next      = segment_reg;
        count_next        = count_reg + 10'd1;
        sector_index_next = sector_index_reg;
        if (seg_end)
        begin
            segment_next = seg_after;
            count_next   = 10'd0;
            if (segment_reg == SEG_GAP4 && seg_after == SEG_GAP2A)
            begin
                sector_index_next = sector_plus[3:0];
            end
            else if (seg_after == SEG_GAP1)
            begin
                sector_index_next = 4'd0;
            end
        end
        crc_next    = crc_en ? crc_byte(crc_base, byte_val) : crc_reg;
        offset_next = eot ? 13'd0 : offset_reg + 13'd1;
    end

    // sequencer state, stepped once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_reg      <= SEG_GAP1;
            count_reg        <= 10'd0;
            sector_index_reg <= 4'd0;
            crc_reg          <= CRC_SEED;
            offset_reg       <= 13'd0;
        end
        else if (advance)
        begin
            segment_reg      <= segment_next;
            count_reg        <= count_next;
            sector_index_reg <= sector_index_next;
            crc_reg          <= crc_next;
            offset_reg       <= offset_next;
        end
    end

    assign beat.track_byte     = byte_val;
    assign beat.data_taken     = taken;
    assign beat.track_position = offset_reg;
    assign beat.end_of_track   = eot;

    `MFM_ASSERT(a_sector_range, clk, rst_n, sector_index_reg <= 4'd10, "sector index out of range")
    `MFM_ASSERT(a_count_range, clk, rst_n, count_reg < 10'd664, "segment count overran")
    `MFM_ASSERT_NEXT(a_eot_restart, clk, rst_n, advance && eot, offset_reg == 13'd0, "offset not restarted after end of track")

endmodule

[sv/mfm_track_formatter.sv]
// top level of the mfm track formatter: config registers and output stage
// Usage
// din carries one pending sector data byte per beat; every accepted din beat
// yields exactly one dout beat holding the next raw track byte, its byte
// offset in the track, an end of track flag and data_taken. When data_taken
// is low the data byte of that beat was not used and the source presents it
// again on the next beat. The track is 6250 bytes and repeats endlessly.
// dout valid rises in the cycle after din accept; throughput is one beat per
// cycle unless dout stalls, set by the segment sequencer and byte-wide crc step.
// The output register stays loaded while dout is stalled; din is refused only
// while a held result is not taken in the same cycle.
// cfg_we writes cfg_data into the register chosen by cfg_index (track number,
// side, sector count); change it only while the block is idle.
// Reset (rst_n low, asynchronous) returns to the start of gap 1 with the crc
// seeded, track 0, side 0 and nine sectors, and empties the output register.
`include "assert_macros.svh"

module mfm_track_formatter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mfm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mfm_pkg::CFG_DATA_W-1:0]   cfg_data,
    mfm_in_if.sink                           din,
    mfm_out_if.source                        dout
);
    import mfm_pkg::*;

    cfg_t  cfg_reg;
    beat_t beat;
    beat_t out_reg;
    logic  out_valid_reg, out_valid_next;
    logic  advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_number <= 7'd0;
            cfg_reg.side_select  <= 1'b0;
            cfg_reg.sector_total <= 4'd9;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRACK:   cfg_reg.track_number <= cfg_data;
                CFG_SIDE:    cfg_reg.side_select  <= cfg_data[0];
                CFG_SECTORS: cfg_reg.sector_total <= cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // accept while the output stage is empty or draining
    assign din.ready = !out_valid_reg || dout.ready;
    assign advance   = din.valid && din.ready;

    mfm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .advance   (advance),
        .data_byte (din.data_byte),
        .beat      (beat)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= beat;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.track_byte     = out_reg.track_byte;
    assign dout.data_taken     = out_reg.data_taken;
    assign dout.track_position = out_reg.track_position;
    assign dout.end_of_track   = out_reg.end_of_track;

    `MFM_ASSERT(a_eot_gap, clk, rst_n, !(dout.valid && dout.end_of_track) || (dout.track_byte == GAP_BYTE && !dout.data_taken), "end of track beat is not a gap byte")
    `MFM_ASSERT(a_stall_blocks, clk, rst_n, !(dout.valid && !dout.ready) || !din.ready, "input accepted over a stalled result")
    `MFM_ASSERT_NEXT(a_accept_valid, clk, rst_n, din.valid && din.ready, dout.valid, "accepted beat produced no result")

endmodule

[test/mfm_track_checker.sv]
// track beat checker: tracks the formatter state, predicts each track beat and compares
`timescale 1ns / 1ps

module mfm_track_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mfm_pkg::CFG_DATA_W-1:0]  cfg_data,
    mfm_in_if                               din,
    mfm_out_if                              dout,
    output int unsigned                     fail_count,
    output int unsigned                     pending,
    output int unsigned                     track_ends,
    output int unsigned                     beats_checked
);
    import mfm_pkg::*;

    localparam int unsigned MIN_SECTORS = 9;
    localparam int unsigned MAX_SECTORS = 11;

    // gap layout rows
    localparam logic [1:0] ROW_NINE   = 2'd0;
    localparam logic [1:0] ROW_TEN    = 2'd1;
    localparam logic [1:0] ROW_ELEVEN = 2'd2;

    // register copies
    logic [6:0]  track_cfg;
    logic        side_cfg;
    logic [3:0]  sector_cfg;

    // sequencer copy
    segment_t    segment;
    logic [9:0]  seg_count;
    logic [3:0]  sector_idx;
    logic [15:0] crc_acc;
    logic [12:0] offset;

    beat_t       track_beats_due [$];
    beat_t       want;
    beat_t       got;

    // layout row picked by the sector count, out of range clamps to the nearest row
    function automatic logic [1:0] layout_row(input logic [3:0] sectors);
        if (sectors < MIN_SECTORS)
            return ROW_NINE;
        if (sectors > MAX_SECTORS)
            return ROW_ELEVEN;
        return (sectors == MIN_SECTORS) ? ROW_NINE : ((sectors == MAX_SECTORS) ? ROW_ELEVEN : ROW_TEN);
    endfunction

    // gap run length for one layout row and gap column
    function automatic int unsigned gap_bytes(input logic [1:0] row, input logic [2:0] col);
        logic compact;
        compact = (row == ROW_ELEVEN);
        case (col)
            GAP_1:    return compact ? 10 : 60;
            GAP_2_00: return compact ? 3 : 12;
            GAP_2_A1: return 3;
            GAP_3_4E: return 22;
            GAP_3_00: return 12;
            GAP_3_A1: return 3;
            GAP_4:    return compact ? 1 : 40;
            default:  return compact ? 14 : ((row == ROW_NINE) ? 664 : 50);
        endcase
    endfunction

    // ccitt crc, one input bit per shift
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // next raw track byte and sequencer advance for one accepted data beat
    task automatic advance_track(input logic [7:0] in_byte, output beat_t res);
        logic [1:0]  row;
        int unsigned nsec;
        int unsigned len;
        segment_t    nxt;
        logic [7:0]  b;
        logic        taken;
        logic        eot;
        row = layout_row(sector_cfg);
        nsec = MIN_SECTORS + 32'(row);
        b = GAP_BYTE;
        len = 1;
        nxt = SEG_GAP1;
        taken = 1'b0;
        eot = 1'b0;
        res.track_position = offset;
        case (segment)
            SEG_GAP1:
            begin
                len = gap_bytes(row, GAP_1);
                nxt = SEG_GAP2A;
            end
            SEG_GAP2A:
            begin
                b = ZERO_BYTE;
                len = gap_bytes(row, GAP_2_00);
                nxt = SEG_GAP2B;
            end
            SEG_GAP2B:
            begin
                // every sync run starts a fresh crc
                if (seg_count == 0)
                    crc_acc = CRC_SEED;
                b = SYNC_BYTE;
                len = gap_bytes(row, GAP_2_A1);
                nxt = SEG_IDAM;
            end
            SEG_IDAM:
            begin
                b = IDAM_BYTE;
                len = 32'(MARK_LEN);
                nxt = SEG_IDBODY;
            end
            SEG_IDBODY:
            begin
                case (seg_count)
                    10'd0:   b = {1'b0, track_cfg};
                    10'd1:   b = {7'd0, side_cfg};
                    10'd2:   b = {4'd0, sector_idx} + 8'd1;
                    default: b = SIZE_CODE;
                endcase
                len = 32'(IDBODY_LEN);
                nxt = SEG_IDCRC;
            end
            SEG_IDCRC:
            begin
                b = (seg_count == 0) ? crc_acc[15:8] : crc_acc[7:0];
                len = 32'(CRC_LEN);
                nxt = SEG_GAP3A;
            end
            SEG_GAP3A:
            begin
                len = gap_bytes(row, GAP_3_4E);
                nxt = SEG_GAP3B1;
            end
            SEG_GAP3B1:
            begin
                b = ZERO_BYTE;
                len = gap_bytes(row, GAP_3_00);
                nxt = SEG_GAP3B2;
            end
            SEG_GAP3B2:
            begin
                if (seg_count == 0)
                    crc_acc = CRC_SEED;
                b = SYNC_BYTE;
                len = gap_bytes(row, GAP_3_A1);
                nxt = SEG_DAM;
            end
            SEG_DAM:
            begin
                b = DAM_BYTE;
                len = 32'(MARK_LEN);
                nxt = SEG_DATA;
            end
            SEG_DATA:
            begin
                b = in_byte;
                taken = 1'b1;
                len = 32'(SECTOR_BYTES);
                nxt = SEG_DATACRC;
            end
            SEG_DATACRC:
            begin
                b = (seg_count == 0) ? crc_acc[15:8] : crc_acc[7:0];
                len = 32'(CRC_LEN);
                nxt = SEG_GAP4;
            end
            SEG_GAP4:
            begin
                len = gap_bytes(row, GAP_4);
                nxt = (int'(sector_idx) + 1 >= nsec) ? SEG_GAP5 : SEG_GAP2A;
            end
            default:
            begin
                len = gap_bytes(row, GAP_5);
                nxt = SEG_GAP1;
            end
        endcase

        // crc covers the sync bytes, the marks and the field bodies
        if (segment inside {SEG_GAP2B, SEG_IDAM, SEG_IDBODY, SEG_GAP3B2, SEG_DAM, SEG_DATA})
            crc_acc = crc_ccitt_step(crc_acc, b);

        // segment advance, a run already past a shortened length ends at once
        if (int'(seg_count) + 1 >= len)
        begin
            if (segment == SEG_GAP4 && nxt == SEG_GAP2A)
                sector_idx = sector_idx + 4'd1;
            else if (nxt == SEG_GAP1)
            begin
                sector_idx = '0;
                eot = 1'b1;
            end
            segment = nxt;
            seg_count = '0;
        end
        else
            seg_count = seg_count + 10'd1;

        offset = eot ? 13'd0 : offset + 13'd1;

        res.track_byte = b;
        res.data_taken = taken;
        res.end_of_track = eot;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_cfg = '0;
            side_cfg = 1'b0;
            sector_cfg = 4'(MIN_SECTORS);
            segment = SEG_GAP1;
            seg_count = '0;
            sector_idx = '0;
            crc_acc = CRC_SEED;
            offset = '0;
            track_beats_due.delete();
            fail_count = 0;
            track_ends = 0;
            beats_checked = 0;
        end
        else
        begin
            // compare an accepted track beat with the oldest prediction
            if (dout.valid && dout.ready)
            begin
                got = {dout.track_byte, dout.data_taken, dout.track_position, dout.end_of_track};
                if (track_beats_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: track beat with nothing due: byte %02h taken %0d pos %0d end %0d",
                             $time, got.track_byte, got.data_taken, got.track_position,
                             got.end_of_track);
                end
                else
                begin
                    want = track_beats_due.pop_front();
                    beats_checked++;
                    if (want.end_of_track)
                        track_ends++;
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: track beat mismatch: expected byte %02h taken %0d pos %0d end %0d",
                                 $time, want.track_byte, want.data_taken, want.track_position,
                                 want.end_of_track);
                        $display("%0t:                        actual byte %02h taken %0d pos %0d end %0d",
                                 $time, got.track_byte, got.data_taken, got.track_position,
                                 got.end_of_track);
                    end
                end
            end

            // predict from an accepted data beat
            if (din.valid && din.ready)
            begin
                advance_track(din.data_byte, want);
                track_beats_due.push_back(want);
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRACK:   track_cfg = cfg_data[6:0];
                    CFG_SIDE:    side_cfg = cfg_data[0];
                    CFG_SECTORS: sector_cfg = cfg_data[3:0];
                    default:     ;
                endcase
            end
        end
        pending = track_beats_due.size();
    end

endmodule

[test/mfm_track_formatter_test.sv]
// testbench top for the track formatter: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module mfm_track_formatter_test;
    import mfm_pkg::*;

    localparam int unsigned PHASES          = 9;
    localparam int unsigned DRAIN_SLACK     = 4;
    localparam int unsigned PHASE_BEATS     = 120;
    localparam int unsigned DIRECTED_BEATS  = 24;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned beats_sent;
    int unsigned settings_used;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned track_ends;
    int unsigned beats_checked;

    mfm_in_if  din ();
    mfm_out_if dout ();

    mfm_track_formatter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din),
        .dout      (dout)
    );

    mfm_track_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .din           (din),
        .dout          (dout),
        .fail_count    (fail_count),
        .pending       (pending),
        .track_ends    (track_ends),
        .beats_checked (beats_checked)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    // track beat receiver stalls at random
    always @(negedge clk)
    begin
        dout.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // sector data byte, biased towards all zeros and all ones
    function automatic logic [7:0] rand_data_byte();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one data beat, with random idle cycles ahead of it
    task automatic send_data(input logic [7:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            din.valid <= 1'b0;
            @(negedge clk);
        end
        din.valid <= 1'b1;
        din.data_byte <= value;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    // hold off until every predicted track beat has come out
    task automatic drain_beats();
        din.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK)
            @(negedge clk);
    endtask

    // write all three registers, one per cycle
    task automatic write_settings(input logic [6:0] trk, input logic side, input logic [3:0] sectors);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TRACK;
        cfg_data <= trk;
        @(negedge clk);
        cfg_index <= CFG_SIDE;
        cfg_data <= CFG_DATA_W'(side);
        @(negedge clk);
        cfg_index <= CFG_SECTORS;
        cfg_data <= CFG_DATA_W'(sectors);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int unsigned phase;
        logic [6:0]  trk;
        logic        side;
        logic [3:0]  sectors;
        logic [7:0]  value;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TRACK;
        cfg_data = '0;
        din.valid = 1'b0;
        din.data_byte = 8'h00;
        dout.ready = 1'b0;
        tx_idle_pct = 15;
        rx_idle_pct = 64;
        beats_sent = 0;
        settings_used = 0;

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: top track and side, sector count above range, through the id field
        write_settings(7'd127, 1'b1, 4'd15);
        for (int k = 0; k < DIRECTED_BEATS; k++)
        begin
            if (k < 16)
                value = k[0] ? ~(8'h01 << k[3:1]) : (8'h01 << k[3:1]);
            else
                value = {8{k[0]}};
            send_data(value);
        end
        drain_beats();

        // random phases, each carries the track on and stops mid-track for new settings
        for (phase = 0; phase < PHASES; phase++)
        begin
            tx_idle_pct = (phase < 3) ? 15 : ((phase < 6) ? 64 : 0);
            rx_idle_pct = (phase < 3) ? 64 : ((phase < 6) ? 15 : 0);
            trk = 7'($urandom_range(127));
            side = 1'($urandom_range(1));
            case (phase)
                0:
                begin
                    trk = 7'd0;
                    side = 1'b0;
                    sectors = 4'd9;
                end
                1:
                begin
                    trk = 7'd127;
                    side = 1'b1;
                    sectors = 4'd11;
                end
                2:       sectors = 4'd10;
                3:       sectors = 4'd0;
                4:       sectors = 4'd15;
                5:       sectors = 4'd10;
                6:       sectors = 4'd11;
                7:       sectors = 4'd9;
                default: sectors = 4'($urandom_range(15));
            endcase
            write_settings(trk, side, sectors);

            repeat (PHASE_BEATS)
                send_data(rand_data_byte());
            drain_beats();
        end

        $display("ran %0d data beats under %0d register settings and three stall patterns",
                 beats_sent, settings_used);
        $display("checked %0d track beats across %0d track ends", beats_checked, track_ends);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
